/* hw/rtl/vss_pkg.sv */
package vss_pkg;

	localparam int DIGIT_COUNT = 4;
	localparam int DIGIT_LIMIT = (DIGIT_COUNT < 1) ? 1 : ((DIGIT_COUNT > 4) ? 4 : DIGIT_COUNT);

	localparam int SAMPLE_W = 10;
	localparam int VALUE_W  = 13;
	localparam int DIGIT_W  = 4;
	localparam int NDIGITS  = 4;
	localparam int INDEX_W  = 2;
	localparam int SEG_W    = 7;
	localparam int SEL_W    = 8;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	typedef logic [NDIGITS-1:0][DIGIT_W-1:0] digit_vec_t;

	localparam logic [SEG_W-1:0] SEG_TABLE [10] = '{
		7'h5F, 7'h06, 7'h3B, 7'h2F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
	};

	// floor(sample * 625 / 128), 0..4995
	function automatic logic [VALUE_W-1:0] scale_sample(input logic [SAMPLE_W-1:0] sample);
		logic [19:0] prod;
		prod = 20'(sample) * 20'd625;
		return prod[19:7];
	endfunction

	// Reciprocal multiplies, exact for values up to 4995
	function automatic digit_vec_t split_digits(input logic [VALUE_W-1:0] x);
		logic [28:0] p1;
		logic [25:0] p2;
		logic [26:0] p3;
		logic [9:0] q1;
		logic [6:0] q2;
		logic [3:0] q3;
		logic [VALUE_W-1:0] r0;
		logic [9:0] r1;
		logic [6:0] r2;
		digit_vec_t d;
		p1 = 29'(x) * 29'd52429;
		p2 = 26'(x) * 26'd5243;
		p3 = 27'(x) * 27'd8389;
		q1 = p1[28:19];
		q2 = p2[25:19];
		q3 = p3[26:23];
		r0 = x - 13'(q1) * 13'd10;
		r1 = q1 - 10'(q2) * 10'd10;
		r2 = q2 - 7'(q3) * 7'd10;
		d[0] = r0[3:0];
		d[1] = r1[3:0];
		d[2] = r2[3:0];
		d[3] = q3;
		return d;
	endfunction

	function automatic logic [SEG_W-1:0] decode_digit(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] seg;
		case (d)
			4'd0: seg = SEG_TABLE[0];
			4'd1: seg = SEG_TABLE[1];
			4'd2: seg = SEG_TABLE[2];
			4'd3: seg = SEG_TABLE[3];
			4'd4: seg = SEG_TABLE[4];
			4'd5: seg = SEG_TABLE[5];
			4'd6: seg = SEG_TABLE[6];
			4'd7: seg = SEG_TABLE[7];
			4'd8: seg = SEG_TABLE[8];
			4'd9: seg = SEG_TABLE[9];
			default: seg = '0;
		endcase
		return seg;
	endfunction

endpackage

/* hw/rtl/vss_req_if.sv */
interface vss_req_if;
	logic valid;
	logic ready;
	logic op;
	logic [vss_pkg::SAMPLE_W-1:0] adc_sample;

	modport source (output valid, output op, output adc_sample, input ready);
	modport sink (input valid, input op, input adc_sample, output ready);
endinterface

/* hw/rtl/vss_rsp_if.sv */
interface vss_rsp_if;
	logic valid;
	logic ready;
	logic [vss_pkg::SEG_W-1:0] segments;
	logic [vss_pkg::SEL_W-1:0] digit_select;

	modport source (output valid, output segments, output digit_select, input ready);
	modport sink (input valid, input segments, input digit_select, output ready);
endinterface

/* hw/rtl/voltage_seven_segment_scanner.sv */
// Four-digit multiplexed seven-segment scanner. A sample request (op 0) is scaled to
// tenths of a millivolt and its four decimal digits replace the displayed value; it
// gives no response. A tick request (op 1) returns the segment pattern of the digit
// at the scan index with a select byte of 0x80 shifted right by that index, then
// steps the index through DIGIT_COUNT digits. One request is taken every cycle; a
// tick's response passes through the input stage, then the output register, and
// the input stalls only while a response waits unread.
module voltage_seven_segment_scanner (
	input logic clk,
	input logic arst_n,
	vss_req_if.sink req,
	vss_rsp_if.source rsp
);

	logic                            valid_s1;
	logic                            op_s1;
	logic [vss_pkg::VALUE_W-1:0]     value_s1;

	vss_pkg::digit_vec_t             digits_q;
	logic [vss_pkg::INDEX_W-1:0]     index_q;

	logic                            rsp_valid_q;
	logic [vss_pkg::SEG_W-1:0]       segments_q;
	logic [vss_pkg::SEL_W-1:0]       select_q;

	logic                            out_free;
	logic                            go_s1;
	logic                            accept;
	logic [vss_pkg::INDEX_W:0]       index_inc;
	logic [vss_pkg::INDEX_W-1:0]     index_next;

	assign out_free = !rsp_valid_q || rsp.ready;
	assign go_s1    = valid_s1 && ((op_s1 == vss_pkg::OP_SAMPLE) || out_free);
	assign req.ready = !valid_s1 || go_s1;
	assign accept   = req.valid && req.ready;

	assign index_inc  = {1'b0, index_q} + 3'd1;
	assign index_next = (index_inc >= 3'(vss_pkg::DIGIT_LIMIT)) ? '0
		: index_inc[vss_pkg::INDEX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= req.op;
			value_s1 <= vss_pkg::scale_sample(req.adc_sample);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_q <= '0;
			index_q  <= '0;
		end else if (go_s1) begin
			if (op_s1 == vss_pkg::OP_SAMPLE) begin
				digits_q <= vss_pkg::split_digits(value_s1);
			end else begin
				index_q <= index_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (go_s1 && (op_s1 == vss_pkg::OP_TICK)) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && (op_s1 == vss_pkg::OP_TICK)) begin
			segments_q <= vss_pkg::decode_digit(digits_q[index_q]);
			select_q   <= 8'h80 >> index_q;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.segments     = segments_q;
	assign rsp.digit_select = select_q;

endmodule
